// File: hw/rtl/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg - shared types and constants for the darkness-weighted centroid
// Payload structs, widths, register indexes and the probe weight tables.
// ----------------------------------------------------------------------------
package wdc_pkg;

   localparam int MAX_LANES      = 8;
   localparam int NUM_PROBES_DEF = 8;
   localparam int LANE_IDX_W     = $clog2(MAX_LANES);

   localparam int DARK_W   = 8;
   localparam int WEIGHT_W = 6;
   localparam int PROD_W   = 14;
   localparam int TOT_W    = 11;
   localparam int SUM_W    = 16;
   localparam int GAIN_W   = 4;
   localparam int NUM_W    = SUM_W + GAIN_W;
   localparam int MAG_W    = NUM_W - 1;
   localparam int OFFSET_W = 10;
   localparam int MAX_OFFSET = 315;

   localparam logic [DARK_W-1:0] DARK_FULL  = 8'd255;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ARC_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN = 1'd1;

   typedef logic signed [WEIGHT_W-1:0] weight_type;

   typedef struct packed {
      logic [7:0] line_bits;
      logic [7:0] normalize_0;
      logic [7:0] normalize_1;
      logic [7:0] normalize_2;
      logic [7:0] normalize_3;
      logic [7:0] normalize_4;
      logic [7:0] normalize_5;
      logic [7:0] normalize_6;
      logic [7:0] normalize_7;
   } req_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] steer_offset;
      logic [7:0]                 line_mask;
   } rsp_type;

   // Sideband that rides along the division pipeline.
   typedef struct packed {
      logic       neg;
      logic       zero;
      logic [7:0] line_mask;
   } side_type;

   // Signed weight of one probe; probe 0 is leftmost.
   function automatic weight_type lane_weight(input logic arc,
                                              input logic [LANE_IDX_W-1:0] idx);
      weight_type w;
      w = '0;
      if (arc) begin
         case (idx)
            3'd0:    w = 6'sd0;
            3'd1:    w = 6'sd21;
            3'd2:    w = 6'sd20;
            3'd3:    w = 6'sd8;
            3'd4:    w = -6'sd8;
            3'd5:    w = -6'sd20;
            3'd6:    w = -6'sd21;
            3'd7:    w = 6'sd0;
            default: w = 6'sd0;
         endcase
      end else begin
         case (idx)
            3'd0:    w = 6'sd20;
            3'd1:    w = 6'sd17;
            3'd2:    w = 6'sd3;
            3'd3:    w = 6'sd1;
            3'd4:    w = -6'sd1;
            3'd5:    w = -6'sd3;
            3'd6:    w = -6'sd17;
            3'd7:    w = -6'sd20;
            default: w = 6'sd0;
         endcase
      end
      return w;
   endfunction

endpackage

// File: hw/rtl/wdc_lane.sv
// ----------------------------------------------------------------------------
// wdc_lane - one probe lane
// Darkness of an on-line probe and its weighted product, registered.
// ----------------------------------------------------------------------------
module wdc_lane
   import wdc_pkg::*;
#(
   parameter int LANE_IDX = 0
) (
   input  logic              clock,
   input  logic              load,
   input  logic              on_line,
   input  logic [DARK_W-1:0] value,
   input  logic              arc_mode,
   output logic [DARK_W-1:0] dark_ff,
   output logic [PROD_W-1:0] prod_ff
);

   logic [DARK_W-1:0]            dark_in;
   logic [PROD_W-1:0]            prod_in;
   weight_type                   weight;
   logic signed [WEIGHT_W+DARK_W:0] prod_full;

   always_comb begin
      dark_in   = on_line ? (DARK_FULL - value) : '0;
      weight    = lane_weight(arc_mode, LANE_IDX_W'(LANE_IDX));
      prod_full = weight * $signed({1'b0, dark_in});
      prod_in   = prod_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dark_ff <= dark_in;
         prod_ff <= prod_in;
      end
   end

endmodule

// File: hw/rtl/wdc_merge.sv
// ----------------------------------------------------------------------------
// wdc_merge - lane merge and gain
// Sums lane darkness and weighted products, then applies the steering gain
// and splits the numerator into sign and magnitude.
// ----------------------------------------------------------------------------
module wdc_merge
   import wdc_pkg::*;
#(
   parameter int LANES = NUM_PROBES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   output logic                         in_rdy,
   input  logic [LANES-1:0][DARK_W-1:0] in_dark,
   input  logic [LANES-1:0][PROD_W-1:0] in_prod,
   input  logic [7:0]                   in_mask,
   input  logic [GAIN_W-1:0]            gain,
   output logic                         out_vld,
   input  logic                         out_rdy,
   output logic [MAG_W-1:0]             out_mag,
   output logic [TOT_W-1:0]             out_total,
   output side_type                     out_side
);

   logic                    vld_a_ff;
   logic [TOT_W-1:0]        tot_a_ff;
   logic signed [SUM_W-1:0] wsum_a_ff;
   logic [7:0]              mask_a_ff;
   logic [TOT_W-1:0]        tot_a_in;
   logic signed [SUM_W-1:0] wsum_a_in;

   logic                    vld_b_ff;
   logic [MAG_W-1:0]        mag_b_ff;
   logic [TOT_W-1:0]        tot_b_ff;
   side_type                side_b_ff;
   logic [MAG_W-1:0]        mag_b_in;
   side_type                side_b_in;
   logic signed [NUM_W:0]   num;

   logic rdy_a;
   logic rdy_b;

   assign rdy_b  = !vld_b_ff || out_rdy;
   assign rdy_a  = !vld_a_ff || rdy_b;
   assign in_rdy = rdy_a;

   always_comb begin
      tot_a_in  = '0;
      wsum_a_in = '0;
      for (int i = 0; i < LANES; i++) begin
         tot_a_in  = tot_a_in + TOT_W'(in_dark[i]);
         wsum_a_in = wsum_a_in + SUM_W'($signed(in_prod[i]));
      end
   end

   always_comb begin
      num                 = wsum_a_ff * $signed({1'b0, gain});
      side_b_in.neg       = num[NUM_W];
      side_b_in.zero      = (tot_a_ff == '0);
      side_b_in.line_mask = mask_a_ff;
      mag_b_in            = num[NUM_W] ? MAG_W'(-num) : num[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            vld_a_ff <= in_vld;
         end
         if (rdy_b) begin
            vld_b_ff <= vld_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld && rdy_a) begin
         tot_a_ff  <= tot_a_in;
         wsum_a_ff <= wsum_a_in;
         mask_a_ff <= in_mask;
      end
      if (vld_a_ff && rdy_b) begin
         mag_b_ff  <= mag_b_in;
         tot_b_ff  <= tot_a_ff;
         side_b_ff <= side_b_in;
      end
   end

   assign out_vld   = vld_b_ff;
   assign out_mag   = mag_b_ff;
   assign out_total = tot_b_ff;
   assign out_side  = side_b_ff;

endmodule

// File: hw/rtl/wdc_divider.sv
// ----------------------------------------------------------------------------
// wdc_divider - pipelined restoring divider
// One quotient bit per stage; each stage holds its own transfer.
// ----------------------------------------------------------------------------
module wdc_divider
   import wdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   output logic             in_rdy,
   input  logic [MAG_W-1:0] in_mag,
   input  logic [TOT_W-1:0] in_div,
   input  side_type         in_side,
   output logic             out_vld,
   input  logic             out_rdy,
   output logic [MAG_W-1:0] out_quo,
   output side_type         out_side
);

   localparam int STEPS = MAG_W;

   logic [STEPS-1:0]            vld_ff;
   logic [TOT_W-1:0]            rem_ff  [STEPS];
   logic [MAG_W-1:0]            quo_ff  [STEPS];
   logic [TOT_W-1:0]            div_ff  [STEPS];
   side_type                    side_ff [STEPS];

   logic [STEPS-1:0]            rdy;
   logic [STEPS-1:0]            src_vld;
   logic [TOT_W-1:0]            src_rem  [STEPS];
   logic [MAG_W-1:0]            src_quo  [STEPS];
   logic [TOT_W-1:0]            src_div  [STEPS];
   side_type                    src_side [STEPS];
   logic [TOT_W:0]              trial    [STEPS];
   logic [STEPS-1:0]            fits;
   logic [TOT_W-1:0]            rem_in   [STEPS];
   logic [MAG_W-1:0]            quo_in   [STEPS];

   always_comb begin
      rdy[STEPS-1] = !vld_ff[STEPS-1] || out_rdy;
      for (int k = STEPS - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      src_vld[0]  = in_vld;
      src_rem[0]  = '0;
      src_quo[0]  = in_mag;
      src_div[0]  = in_div;
      src_side[0] = in_side;
      for (int k = 1; k < STEPS; k++) begin
         src_vld[k]  = vld_ff[k-1];
         src_rem[k]  = rem_ff[k-1];
         src_quo[k]  = quo_ff[k-1];
         src_div[k]  = div_ff[k-1];
         src_side[k] = side_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         trial[k]  = {src_rem[k], src_quo[k][MAG_W-1]};
         fits[k]   = (trial[k] >= {1'b0, src_div[k]});
         rem_in[k] = fits[k] ? TOT_W'(trial[k] - {1'b0, src_div[k]})
                             : trial[k][TOT_W-1:0];
         quo_in[k] = {src_quo[k][MAG_W-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STEPS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= src_vld[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         if (src_vld[k] && rdy[k]) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            div_ff[k]  <= src_div[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign in_rdy   = rdy[0];
   assign out_vld  = vld_ff[STEPS-1];
   assign out_quo  = quo_ff[STEPS-1];
   assign out_side = side_ff[STEPS-1];

endmodule

// File: hw/rtl/weighted_darkness_centroid.sv
// ----------------------------------------------------------------------------
// weighted_darkness_centroid - line position from one 8-probe reading
// Lanes, merge, gain, division pipeline and result register.
// ----------------------------------------------------------------------------
// One reading goes in per transfer and one result comes out per reading, in
// order. Each probe whose line bit is 0 adds its darkness (255 minus its
// brightness) to a total and darkness times its signed weight (straight or
// arc table, picked by arc_mode) to a weighted sum; steer_offset is
// weighted sum times steer_gain divided by the total, truncated toward zero,
// and 0 when the total is 0. line_mask flags the probes on the line; probes
// at or above NUM_PROBES (capped at 8) count as off the line. The block takes
// a new reading every cycle while req_stall is low. It has one lane stage,
// one sum stage, one gain multiply stage, 19 divider stages (one quotient
// bit each) and the result register. Every stage holds its data while the
// stage after it is full and cannot accept, so stall on the result side
// backs up to req_stall only once the pipeline is full. Write arc_mode and
// steer_gain only with no reading in flight.
// ----------------------------------------------------------------------------
module weighted_darkness_centroid
   import wdc_pkg::*;
#(
   parameter int NUM_PROBES = NUM_PROBES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LANE_COUNT = (NUM_PROBES < MAX_LANES) ? NUM_PROBES : MAX_LANES;

   // Configuration registers
   logic              arc_mode_ff;
   logic [GAIN_W-1:0] steer_gain_ff;

   // Lane stage
   logic [MAX_LANES-1:0][DARK_W-1:0]  probe_val;
   logic [7:0]                        on_line;
   logic                              s1_vld_ff;
   logic [7:0]                        s1_mask_ff;
   logic                              s1_rdy;
   logic                              req_xfer;
   logic [LANE_COUNT-1:0][DARK_W-1:0] lane_dark;
   logic [LANE_COUNT-1:0][PROD_W-1:0] lane_prod;

   // Merge to divider
   logic             mrg_rdy;
   logic             mrg_vld;
   logic [MAG_W-1:0] mrg_mag;
   logic [TOT_W-1:0] mrg_total;
   side_type         mrg_side;
   logic             div_in_rdy;

   // Divider to result register
   logic             div_vld;
   logic [MAG_W-1:0] div_quo;
   side_type         div_side;
   logic             out_rdy;

   logic                       rsp_vld_ff;
   rsp_type                    rsp_data_ff;
   rsp_type                    rsp_data_in;
   logic signed [OFFSET_W-1:0] offset_mag;

   // ---- configuration writes ------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         arc_mode_ff   <= 1'b0;
         steer_gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ARC_MODE:   arc_mode_ff   <= csr_wdata[0];
            CSR_STEER_GAIN: steer_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- lane stage ----------------------------------------------------------
   // Accept while the lane registers are empty or draining into the merge.
   assign s1_rdy    = !s1_vld_ff || mrg_rdy;
   assign req_stall = !s1_rdy;
   assign req_xfer  = req_valid && s1_rdy;

   always_comb begin
      probe_val[0] = req_data.normalize_0;
      probe_val[1] = req_data.normalize_1;
      probe_val[2] = req_data.normalize_2;
      probe_val[3] = req_data.normalize_3;
      probe_val[4] = req_data.normalize_4;
      probe_val[5] = req_data.normalize_5;
      probe_val[6] = req_data.normalize_6;
      probe_val[7] = req_data.normalize_7;
      // Drop probes beyond the configured count.
      for (int i = 0; i < 8; i++) begin
         on_line[i] = (i < LANE_COUNT) && !req_data.line_bits[i];
      end
   end

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      wdc_lane #(
         .LANE_IDX (g)
      ) u_lane (
         .clock    (clock),
         .load     (req_xfer),
         .on_line  (on_line[g]),
         .value    (probe_val[g]),
         .arc_mode (arc_mode_ff),
         .dark_ff  (lane_dark[g]),
         .prod_ff  (lane_prod[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mask_ff <= on_line;
      end
   end

   // ---- merge and gain ------------------------------------------------------
   wdc_merge #(
      .LANES (LANE_COUNT)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (s1_vld_ff),
      .in_rdy    (mrg_rdy),
      .in_dark   (lane_dark),
      .in_prod   (lane_prod),
      .in_mask   (s1_mask_ff),
      .gain      (steer_gain_ff),
      .out_vld   (mrg_vld),
      .out_rdy   (div_in_rdy),
      .out_mag   (mrg_mag),
      .out_total (mrg_total),
      .out_side  (mrg_side)
   );

   // ---- division ------------------------------------------------------------
   wdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (mrg_vld),
      .in_rdy   (div_in_rdy),
      .in_mag   (mrg_mag),
      .in_div   (mrg_total),
      .in_side  (mrg_side),
      .out_vld  (div_vld),
      .out_rdy  (out_rdy),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   // ---- result register -----------------------------------------------------
   // Advance when the register is empty or its transfer completes this cycle.
   assign out_rdy = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      offset_mag            = $signed(div_quo[OFFSET_W-1:0]);
      rsp_data_in.line_mask = div_side.line_mask;
      // No darkness means no position: force the offset to zero.
      if (div_side.zero) begin
         rsp_data_in.steer_offset = '0;
      end else if (div_side.neg) begin
         rsp_data_in.steer_offset = -offset_mag;
      end else begin
         rsp_data_in.steer_offset = offset_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (div_vld && out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----------------------------------------------------------
   // Stall toward the sender only when the lane stage holds a reading.
   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff
   ) else $error("req_stall raised with an empty lane stage");

   // A weighted average of weights times the gain stays in the field range.
   a_quotient_range: assert property (
      @(posedge clock) disable iff (reset)
      (div_vld && !div_side.zero) |-> (div_quo <= MAG_W'(MAX_OFFSET))
   ) else $error("divider quotient exceeds the offset range");

   // Probes beyond the lane count never show up in the mask.
   a_mask_in_lanes: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.line_mask >> LANE_COUNT) == '0)
   ) else $error("line_mask flags a probe beyond the lane count");

endmodule
